FILE: hw/rtl/region_checked_memory_unit_defines.svh
// Assertion macros for the region checked memory unit.
// Included by the top level; no other dependencies.
`ifndef REGION_CHECKED_MEMORY_UNIT_DEFINES_SVH
`define REGION_CHECKED_MEMORY_UNIT_DEFINES_SVH

// assert that a condition implies a consequence on the same edge
`define RCM_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// assert that a condition implies a consequence on the next edge
`define RCM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the region checked memory unit.
// No dependencies.
package rcm_pkg;
  localparam int MaxRegions = 8;
  localparam int StoreBytes = 65536;
  localparam int RegIdxW = $clog2(MaxRegions);
  localparam int CountW = $clog2(MaxRegions + 1);
  localparam int OffW = $clog2(StoreBytes + 1);
  localparam int StoreAw = $clog2(StoreBytes);
  localparam int WordAw = StoreAw - 3;
  localparam int StoreWords = StoreBytes / 8;

  typedef enum logic [1:0] {
    KIND_DEFINE  = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_STORE   = 2'd2,
    KIND_PRELOAD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_PERM  = 2'd2,
    ST_SIZE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACCESS,
    BK_CLEAR
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [7:0]  access_width;
    logic [63:0] region_length;
    logic        region_writable;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [3:0]  region_count;
  } out_item_t;

  // classified job passed from front to back
  typedef struct packed {
    logic             is_clear;
    logic             do_read;
    logic             do_write;
    logic [1:0]       status;
    logic [StoreAw:0] start;
    logic [3:0]       width;
    logic [63:0]      write_data;
    logic [3:0]       region_count;
  } job_t;
endpackage

FILE: hw/rtl/region_checked_memory_unit.sv
`timescale 1ns / 1ps
// Region checked memory unit: front part classifies against the region table,
// a two-entry job queue feeds the back part that owns the byte store.
// Depends on rcm_pkg, rcm_front, rcm_job_queue, rcm_back.
//
// One result per item, in order. The input takes no new item while the front
// part holds one, so that the next item is compared against the updated region
// table. Accepted loads, stores and preloads take an extra step when the access
// does not start on an 8-byte store word boundary, set by the single store port
// (read, then write or second read). A rejected define runs a clearing pass over
// the store before its result appears; the same pass runs after reset before the
// first item is carried out.
`include "region_checked_memory_unit_defines.svh"
module region_checked_memory_unit import rcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);
  logic in_ready;
  logic fq_valid;
  job_t fq_job;
  logic fq_ready;
  logic bq_valid;
  job_t bq_job;
  logic bq_ready;
  logic res_valid;

  assign full = !in_ready;
  assign empty = !res_valid;

  rcm_front u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_item(in_item), .in_ready(in_ready),
    .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
  );

  rcm_job_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fq_valid), .wr_job(fq_job), .wr_ready(fq_ready),
    .rd_valid(bq_valid), .rd_job(bq_job), .rd_ready(bq_ready)
  );

  rcm_back u_back (
    .clk(clk), .rst(rst), .job_valid(bq_valid), .job(bq_job), .job_ready(bq_ready),
    .res_valid(res_valid), .res(out_item), .res_ready(pop)
  );

  `RCM_ASSERT_IMP(a_count_bound, clk, rst, !empty, out_item.region_count <= 4'(MaxRegions),
    "region count above table size")
  `RCM_ASSERT_IMP(a_fault_no_data, clk, rst, !empty && out_item.status != ST_OK,
    out_item.read_data == 64'd0, "read data on a faulted item")
  `RCM_ASSERT_NEXT(a_hold_result, clk, rst, !empty && !pop, !empty,
    "result dropped before transfer")
endmodule

FILE: hw/rtl/rcm_front.sv
`timescale 1ns / 1ps
// Front part: region table, define checks and access classification.
// Depends on rcm_pkg.
module rcm_front import rcm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_ready
);
  logic [63:0]        base_tab [MaxRegions];
  logic [63:0]        len_tab  [MaxRegions];
  logic [MaxRegions-1:0] wr_tab;
  logic [OffW-1:0]    off_tab  [MaxRegions];
  logic [CountW-1:0]  count;
  logic [OffW-1:0]    free_off;

  logic               stage_valid;
  in_item_t           stage;
  logic [MaxRegions-1:0] hit_vec;
  logic [MaxRegions-1:0] meet_vec;
  logic               room_bad;
  logic               base_bad;

  logic [MaxRegions-1:0] hit_c;
  logic [MaxRegions-1:0] meet_c;
  logic [64:0]        end_sum;
  logic               define_ok;
  logic               width_ok;
  logic [RegIdxW-1:0] hit_idx;
  logic               any_hit;
  logic [64:0]        start_w;
  job_t               job_c;

  // stage 1 compares, stage 2 emits job
  assign in_ready = !stage_valid;

  always_comb begin
    for (int j = 0; j < MaxRegions; j++) begin
      logic [63:0] d;
      logic act;
      d = in_item.address - base_tab[j];
      act = (j < int'(count));
      hit_c[j] = act && (in_item.address >= base_tab[j]) && (d <= len_tab[j]) &&
                 ({56'd0, in_item.access_width} <= len_tab[j] - d);
      if (in_item.address <= base_tab[j])
        meet_c[j] = act && (in_item.address + in_item.region_length > base_tab[j]);
      else
        meet_c[j] = act && (base_tab[j] + len_tab[j] > in_item.address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stage_valid) begin
      stage_valid <= in_valid;
    end else if (job_ready) begin
      stage_valid <= 1'b0;
    end
    if (in_ready) begin
      stage <= in_item;
      hit_vec <= hit_c;
      meet_vec <= meet_c;
      room_bad <= {1'b0, in_item.region_length} >
                  {{(65-OffW){1'b0}}, OffW'(StoreBytes)} - {{(65-OffW){1'b0}}, free_off};
      base_bad <= !(in_item.region_length < (64'd0 - in_item.address));
    end
  end

  always_comb begin
    end_sum = '0;
    define_ok = !base_bad && (stage.region_length != 64'd0) &&
                (count < CountW'(MaxRegions)) && (meet_vec == '0) && !room_bad;
    width_ok = (stage.access_width == 8'd1) || (stage.access_width == 8'd2) ||
               (stage.access_width == 8'd4) || (stage.access_width == 8'd8);
    hit_idx = '0;
    any_hit = 1'b0;
    for (int j = MaxRegions - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = RegIdxW'(j);
        any_hit = 1'b1;
      end
    end
    start_w = {{(65-OffW){1'b0}}, off_tab[hit_idx]} +
              {1'b0, stage.address - base_tab[hit_idx]};
    job_c = '0;
    job_c.width = stage.access_width[3:0];
    job_c.write_data = stage.write_data;
    job_c.start = start_w[StoreAw:0];
    job_c.status = ST_OK;
    priority if (stage.kind == KIND_DEFINE) begin
      job_c.is_clear = !define_ok;
      job_c.status = define_ok ? ST_OK : ST_ADDR;
      job_c.region_count = define_ok ? 4'(count + 1'b1) : 4'd0;
    end else if (!width_ok) begin
      job_c.status = ST_SIZE;
      job_c.region_count = 4'(count);
    end else if (!any_hit) begin
      job_c.status = ST_ADDR;
      job_c.region_count = 4'(count);
    end else if (stage.kind == KIND_STORE && !wr_tab[hit_idx]) begin
      job_c.status = ST_PERM;
      job_c.region_count = 4'(count);
    end else begin
      job_c.do_read = (stage.kind == KIND_LOAD);
      job_c.do_write = (stage.kind != KIND_LOAD);
      job_c.region_count = 4'(count);
    end
    end_sum[OffW-1:0] = free_off + stage.region_length[OffW-1:0];
  end

  assign job_valid = stage_valid;
  assign job = job_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      free_off <= '0;
      wr_tab <= '0;
      for (int j = 0; j < MaxRegions; j++) begin
        base_tab[j] <= '0;
        len_tab[j] <= '0;
        off_tab[j] <= '0;
      end
    end else if (stage_valid && job_ready && stage.kind == KIND_DEFINE) begin
      if (define_ok) begin
        base_tab[count[RegIdxW-1:0]] <= stage.address;
        len_tab[count[RegIdxW-1:0]] <= stage.region_length;
        wr_tab[count[RegIdxW-1:0]] <= stage.region_writable;
        off_tab[count[RegIdxW-1:0]] <= free_off;
        free_off <= end_sum[OffW-1:0];
        count <= count + 1'b1;
      end else begin
        count <= '0;
        free_off <= '0;
        wr_tab <= '0;
        for (int j = 0; j < MaxRegions; j++) begin
          base_tab[j] <= '0;
          len_tab[j] <= '0;
          off_tab[j] <= '0;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/rcm_job_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back parts.
// Depends on rcm_pkg.
module rcm_job_queue import rcm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  job_t wr_job,
  output logic wr_ready,
  output logic rd_valid,
  output job_t rd_job,
  input  logic rd_ready
);
  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] used;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (used != 2'd2);
  assign rd_valid = (used != 2'd0);
  assign rd_job = slots[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= '0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      used <= used + {1'b0, do_wr} - {1'b0, do_rd};
    end
    if (do_wr) slots[wptr] <= wr_job;
  end
endmodule

FILE: hw/rtl/rcm_back.sv
`timescale 1ns / 1ps
// Back part: word-organised byte store, access sequencing, clearing pass.
// Depends on rcm_pkg.
module rcm_back import rcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_ready,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_ready
);
  logic [63:0]       mem [StoreWords];
  back_state_t       state;
  back_state_t       state_next;
  job_t              cur;
  logic              cur_part;
  logic              init_clr;
  logic [WordAw:0]   clr_addr;
  logic [WordAw-1:0] word_addr;
  logic [63:0]       rd_word;
  logic [63:0]       lo_word;
  logic [7:0]        byte_mask;
  logic [15:0]       mask2;
  logic [127:0]      data2;
  logic [127:0]      rd_pair;
  logic [63:0]       width_mask;
  logic [2:0]        sh;
  logic [StoreAw:0]  hi_start;
  logic              span2;
  logic              out_full;
  logic              load_out;
  logic              take_job;

  assign sh = cur.start[2:0];
  assign hi_start = cur.start + (StoreAw+1)'(4'd8);
  assign span2 = (sh != 3'd0);
  assign out_full = res_valid && !res_ready;
  assign job_ready = (state == BK_IDLE) && !out_full && !cur_part;
  assign take_job = job_valid && job_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take_job && job.is_clear) state_next = BK_CLEAR;
        else if (take_job && (job.do_read || job.do_write)) state_next = BK_ACCESS;
      end
      BK_ACCESS: begin
        if (!out_full && (!span2 || cur_part)) state_next = BK_IDLE;
      end
      BK_CLEAR: begin
        if (clr_addr[WordAw] && !out_full) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    width_mask = '0;
    for (int k = 0; k < 8; k++) width_mask[8*k +: 8] = (k < int'(cur.width)) ? 8'hff : 8'h00;
    byte_mask = '0;
    for (int k = 0; k < 8; k++) byte_mask[k] = (k < int'(cur.width));
    mask2 = {8'd0, byte_mask} << sh;
    data2 = {64'd0, cur.write_data & width_mask} << {sh, 3'b000};
    // accept cycle reads low word, first access cycle reads high word
    word_addr = (state == BK_IDLE) ? job.start[StoreAw-1:3] : hi_start[StoreAw-1:3];
    rd_pair = {rd_word, lo_word} >> {sh, 3'b000};
    load_out = (state == BK_ACCESS) && !out_full && (!span2 || cur_part);
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[word_addr];
    if (state == BK_CLEAR && !clr_addr[WordAw]) begin
      mem[clr_addr[WordAw-1:0]] <= '0;
    end else if (state == BK_IDLE && take_job && job.do_write) begin
      for (int k = 0; k < 8; k++) begin
        if (job.start[StoreAw] == 1'b0 && ((({8'd0, 8'hff >> (4'd8 - job.width)}
            << job.start[2:0]) >> k) & 16'd1) != 16'd0)
          mem[job.start[StoreAw-1:3]][8*k +: 8] <= job.write_data[8*(k - int'(job.start[2:0])) +: 8];
      end
    end else if (state == BK_ACCESS && cur.do_write && !cur_part && span2 &&
                 hi_start[StoreAw] == 1'b0) begin
      for (int k = 0; k < 8; k++) begin
        if (mask2[8 + k])
          mem[hi_start[StoreAw-1:3]][8*k +: 8] <= data2[64 + 8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      init_clr <= 1'b1;
      cur_part <= 1'b0;
      clr_addr <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR && clr_addr[WordAw]) init_clr <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == BK_ACCESS && !out_full) cur_part <= span2 && !cur_part;
      if (state == BK_CLEAR && !clr_addr[WordAw]) clr_addr <= clr_addr + 1'b1;
      if (state == BK_IDLE) clr_addr <= '0;
      if (take_job && !job.is_clear && !(job.do_read || job.do_write)) res_valid <= 1'b1;
      if (load_out) res_valid <= 1'b1;
      if (state == BK_CLEAR && clr_addr[WordAw] && !out_full && !init_clr) res_valid <= 1'b1;
    end
    if (take_job) begin
      cur <= job;
      res.status <= job.status;
      res.region_count <= job.region_count;
      res.read_data <= '0;
    end
    if (state == BK_ACCESS && !cur_part) lo_word <= rd_word;
    if (load_out && cur.do_read) begin
      res.read_data <= (span2 ? rd_pair[63:0] : (rd_word >> {sh, 3'b000})) & width_mask &
                       ((cur.start[StoreAw] == 1'b0) ? 64'hffff_ffff_ffff_ffff :
                        64'd0) & ((hi_start[StoreAw] && span2) ?
                        ~(64'hffff_ffff_ffff_ffff << {4'd8 - {1'b0, sh}, 3'b000}) :
                        64'hffff_ffff_ffff_ffff);
    end
  end
endmodule
